// ===== sv/point_on_mesh_face_test_top_defines.svh =====
// Assertion macros for the point-on-mesh face test block.
// Included by the RTL file that carries concurrent assertions; expects clk and rst_n in scope.
`ifndef POINT_ON_MESH_FACE_TEST_TOP_DEFINES_SVH
`define POINT_ON_MESH_FACE_TEST_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define POMF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define POMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pomf_pkg.sv =====
// Shared types, constants and the per-triangle microcode for the point-on-mesh face test.
// No dependencies; imported by pomf_alu and point_on_mesh_face_test_top.
`default_nettype none

package pomf_pkg;

    localparam int unsigned MAX_VERTICES  = 1024;
    localparam int unsigned MAX_TRIANGLES = 1024;
    localparam int unsigned VA_W = $clog2(MAX_VERTICES);
    localparam int unsigned TA_W = $clog2(MAX_TRIANGLES);
    localparam int unsigned FC_W = 11;
    localparam int unsigned THR_W = 20;
    localparam int unsigned COORD_W = 32;

    // Wide datapath: nw^2 and lmin*den stay below 2^203
    localparam int unsigned WIDE_W = 208;
    localparam int unsigned RF_AW  = 5;
    localparam int unsigned NB_W   = 7;
    localparam int unsigned PC_W   = 7;
    localparam int unsigned UC_LEN = 75;

    typedef logic [WIDE_W-1:0] wide_t;

    // Input commands
    localparam logic [1:0] CMD_VERTEX   = 2'd0;
    localparam logic [1:0] CMD_TRIANGLE = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;

    // Configuration register indexes
    localparam logic CFG_THRESHOLD  = 1'b0;
    localparam logic CFG_FACE_COUNT = 1'b1;

    typedef enum logic [2:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_MIN,
        OP_CHKNN,
        OP_CHKPOS
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [NB_W-1:0]  nbits;
    } alu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic fail;
    } alu_stat_t;

    typedef struct packed {
        alu_op_t           op;
        logic [RF_AW-1:0]  dst;
        logic [RF_AW-1:0]  src_a;
        logic [RF_AW-1:0]  src_b;
        logic [NB_W-1:0]   nbits;
    } uc_t;

    // Register file slots
    localparam logic [RF_AW-1:0] R_E1X  = 5'd0;
    localparam logic [RF_AW-1:0] R_E1Y  = 5'd1;
    localparam logic [RF_AW-1:0] R_E1Z  = 5'd2;
    localparam logic [RF_AW-1:0] R_E2X  = 5'd3;
    localparam logic [RF_AW-1:0] R_E2Y  = 5'd4;
    localparam logic [RF_AW-1:0] R_E2Z  = 5'd5;
    localparam logic [RF_AW-1:0] R_WX   = 5'd6;
    localparam logic [RF_AW-1:0] R_WY   = 5'd7;
    localparam logic [RF_AW-1:0] R_WZ   = 5'd8;
    localparam logic [RF_AW-1:0] R_D00  = 5'd9;
    localparam logic [RF_AW-1:0] R_D01  = 5'd10;
    localparam logic [RF_AW-1:0] R_D02  = 5'd11;
    localparam logic [RF_AW-1:0] R_D11  = 5'd12;
    localparam logic [RF_AW-1:0] R_D12  = 5'd13;
    localparam logic [RF_AW-1:0] R_D22  = 5'd14;
    localparam logic [RF_AW-1:0] R_TMP  = 5'd15;
    localparam logic [RF_AW-1:0] R_DEN  = 5'd16;
    localparam logic [RF_AW-1:0] R_NU   = 5'd17;
    localparam logic [RF_AW-1:0] R_NV   = 5'd18;
    localparam logic [RF_AW-1:0] R_NX   = 5'd19;
    localparam logic [RF_AW-1:0] R_NY   = 5'd20;
    localparam logic [RF_AW-1:0] R_NZ   = 5'd21;
    localparam logic [RF_AW-1:0] R_NW   = 5'd22;
    localparam logic [RF_AW-1:0] R_E3X  = 5'd23;
    localparam logic [RF_AW-1:0] R_THR  = 5'd24;
    localparam logic [RF_AW-1:0] R_THR1 = 5'd25;
    localparam logic [RF_AW-1:0] R_ONE  = 5'd26;
    localparam logic [RF_AW-1:0] R_E3Y  = 5'd27;
    localparam logic [RF_AW-1:0] R_E3Z  = 5'd28;
    localparam logic [RF_AW-1:0] R_TW   = 5'd29;
    localparam logic [RF_AW-1:0] R_T2   = 5'd30;
    localparam logic [RF_AW-1:0] R_LMIN = 5'd31;

    // Multiplier lengths: signed width of the second operand
    localparam logic [NB_W-1:0] NB_C = 7'd33;
    localparam logic [NB_W-1:0] NB_D = 7'd68;
    localparam logic [NB_W-1:0] NB_T = 7'd22;
    localparam logic [NB_W-1:0] NB_S = 7'd18;
    localparam logic [NB_W-1:0] NB_N = 7'd104;
    localparam logic [NB_W-1:0] NB_X = 7'd0;

    function automatic uc_t uc_op(alu_op_t op, logic [RF_AW-1:0] d, logic [RF_AW-1:0] a,
                                  logic [RF_AW-1:0] b, logic [NB_W-1:0] nb);
        uc_t u;
        u.op    = op;
        u.dst   = d;
        u.src_a = a;
        u.src_b = b;
        u.nbits = nb;
        return u;
    endfunction

    // Per-triangle program; a failing check skips to the next triangle
    function automatic uc_t uc_rom(logic [PC_W-1:0] pc);
        uc_t u;
        case (pc)
            // d00 = e2.e2
            7'd0:  u = uc_op(OP_MUL, R_D00, R_E2X, R_E2X, NB_C);
            7'd1:  u = uc_op(OP_MUL, R_TMP, R_E2Y, R_E2Y, NB_C);
            7'd2:  u = uc_op(OP_ADD, R_D00, R_D00, R_TMP, NB_X);
            7'd3:  u = uc_op(OP_MUL, R_TMP, R_E2Z, R_E2Z, NB_C);
            7'd4:  u = uc_op(OP_ADD, R_D00, R_D00, R_TMP, NB_X);
            // d01 = e2.e1
            7'd5:  u = uc_op(OP_MUL, R_D01, R_E2X, R_E1X, NB_C);
            7'd6:  u = uc_op(OP_MUL, R_TMP, R_E2Y, R_E1Y, NB_C);
            7'd7:  u = uc_op(OP_ADD, R_D01, R_D01, R_TMP, NB_X);
            7'd8:  u = uc_op(OP_MUL, R_TMP, R_E2Z, R_E1Z, NB_C);
            7'd9:  u = uc_op(OP_ADD, R_D01, R_D01, R_TMP, NB_X);
            // d02 = e2.w
            7'd10: u = uc_op(OP_MUL, R_D02, R_E2X, R_WX, NB_C);
            7'd11: u = uc_op(OP_MUL, R_TMP, R_E2Y, R_WY, NB_C);
            7'd12: u = uc_op(OP_ADD, R_D02, R_D02, R_TMP, NB_X);
            7'd13: u = uc_op(OP_MUL, R_TMP, R_E2Z, R_WZ, NB_C);
            7'd14: u = uc_op(OP_ADD, R_D02, R_D02, R_TMP, NB_X);
            // d11 = e1.e1
            7'd15: u = uc_op(OP_MUL, R_D11, R_E1X, R_E1X, NB_C);
            7'd16: u = uc_op(OP_MUL, R_TMP, R_E1Y, R_E1Y, NB_C);
            7'd17: u = uc_op(OP_ADD, R_D11, R_D11, R_TMP, NB_X);
            7'd18: u = uc_op(OP_MUL, R_TMP, R_E1Z, R_E1Z, NB_C);
            7'd19: u = uc_op(OP_ADD, R_D11, R_D11, R_TMP, NB_X);
            // d12 = e1.w
            7'd20: u = uc_op(OP_MUL, R_D12, R_E1X, R_WX, NB_C);
            7'd21: u = uc_op(OP_MUL, R_TMP, R_E1Y, R_WY, NB_C);
            7'd22: u = uc_op(OP_ADD, R_D12, R_D12, R_TMP, NB_X);
            7'd23: u = uc_op(OP_MUL, R_TMP, R_E1Z, R_WZ, NB_C);
            7'd24: u = uc_op(OP_ADD, R_D12, R_D12, R_TMP, NB_X);
            // e3 = e2 - e1, d22 = e3.e3
            7'd25: u = uc_op(OP_SUB, R_E3X, R_E2X, R_E1X, NB_X);
            7'd26: u = uc_op(OP_SUB, R_E3Y, R_E2Y, R_E1Y, NB_X);
            7'd27: u = uc_op(OP_SUB, R_E3Z, R_E2Z, R_E1Z, NB_X);
            7'd28: u = uc_op(OP_MUL, R_D22, R_E3X, R_E3X, NB_C);
            7'd29: u = uc_op(OP_MUL, R_TMP, R_E3Y, R_E3Y, NB_C);
            7'd30: u = uc_op(OP_ADD, R_D22, R_D22, R_TMP, NB_X);
            7'd31: u = uc_op(OP_MUL, R_TMP, R_E3Z, R_E3Z, NB_C);
            7'd32: u = uc_op(OP_ADD, R_D22, R_D22, R_TMP, NB_X);
            // den, skip degenerate
            7'd33: u = uc_op(OP_MUL, R_DEN, R_D00, R_D11, NB_D);
            7'd34: u = uc_op(OP_MUL, R_TMP, R_D01, R_D01, NB_D);
            7'd35: u = uc_op(OP_SUB, R_DEN, R_DEN, R_TMP, NB_X);
            7'd36: u = uc_op(OP_CHKPOS, R_TMP, R_DEN, R_DEN, NB_X);
            // nu, nv
            7'd37: u = uc_op(OP_MUL, R_NU, R_D11, R_D02, NB_D);
            7'd38: u = uc_op(OP_MUL, R_TMP, R_D01, R_D12, NB_D);
            7'd39: u = uc_op(OP_SUB, R_NU, R_NU, R_TMP, NB_X);
            7'd40: u = uc_op(OP_MUL, R_NV, R_D00, R_D12, NB_D);
            7'd41: u = uc_op(OP_MUL, R_TMP, R_D01, R_D02, NB_D);
            7'd42: u = uc_op(OP_SUB, R_NV, R_NV, R_TMP, NB_X);
            // u >= -t and v >= -t
            7'd43: u = uc_op(OP_MUL, R_TW, R_DEN, R_THR, NB_T);
            7'd44: u = uc_op(OP_MUL, R_TMP, R_NU, R_ONE, NB_S);
            7'd45: u = uc_op(OP_ADD, R_TMP, R_TMP, R_TW, NB_X);
            7'd46: u = uc_op(OP_CHKNN, R_TMP, R_TMP, R_TMP, NB_X);
            7'd47: u = uc_op(OP_MUL, R_TMP, R_NV, R_ONE, NB_S);
            7'd48: u = uc_op(OP_ADD, R_TMP, R_TMP, R_TW, NB_X);
            7'd49: u = uc_op(OP_CHKNN, R_TMP, R_TMP, R_TMP, NB_X);
            // u + v <= 1 + t
            7'd50: u = uc_op(OP_ADD, R_TMP, R_NU, R_NV, NB_X);
            7'd51: u = uc_op(OP_MUL, R_TMP, R_TMP, R_ONE, NB_S);
            7'd52: u = uc_op(OP_MUL, R_T2, R_DEN, R_THR1, NB_T);
            7'd53: u = uc_op(OP_SUB, R_TMP, R_T2, R_TMP, NB_X);
            7'd54: u = uc_op(OP_CHKNN, R_TMP, R_TMP, R_TMP, NB_X);
            // shortest squared edge
            7'd55: u = uc_op(OP_MIN, R_LMIN, R_D11, R_D00, NB_X);
            7'd56: u = uc_op(OP_MIN, R_LMIN, R_LMIN, R_D22, NB_X);
            // n = e1 x e2
            7'd57: u = uc_op(OP_MUL, R_NX, R_E1Y, R_E2Z, NB_C);
            7'd58: u = uc_op(OP_MUL, R_TMP, R_E1Z, R_E2Y, NB_C);
            7'd59: u = uc_op(OP_SUB, R_NX, R_NX, R_TMP, NB_X);
            7'd60: u = uc_op(OP_MUL, R_NY, R_E1Z, R_E2X, NB_C);
            7'd61: u = uc_op(OP_MUL, R_TMP, R_E1X, R_E2Z, NB_C);
            7'd62: u = uc_op(OP_SUB, R_NY, R_NY, R_TMP, NB_X);
            7'd63: u = uc_op(OP_MUL, R_NZ, R_E1X, R_E2Y, NB_C);
            7'd64: u = uc_op(OP_MUL, R_TMP, R_E1Y, R_E2X, NB_C);
            7'd65: u = uc_op(OP_SUB, R_NZ, R_NZ, R_TMP, NB_X);
            // nw = n.w
            7'd66: u = uc_op(OP_MUL, R_NW, R_NX, R_WX, NB_C);
            7'd67: u = uc_op(OP_MUL, R_TMP, R_NY, R_WY, NB_C);
            7'd68: u = uc_op(OP_ADD, R_NW, R_NW, R_TMP, NB_X);
            7'd69: u = uc_op(OP_MUL, R_TMP, R_NZ, R_WZ, NB_C);
            7'd70: u = uc_op(OP_ADD, R_NW, R_NW, R_TMP, NB_X);
            // plane distance below shortest edge
            7'd71: u = uc_op(OP_MUL, R_NW, R_NW, R_NW, NB_N);
            7'd72: u = uc_op(OP_MUL, R_TMP, R_DEN, R_LMIN, NB_D);
            7'd73: u = uc_op(OP_SUB, R_TMP, R_TMP, R_NW, NB_X);
            7'd74: u = uc_op(OP_CHKPOS, R_TMP, R_TMP, R_TMP, NB_X);
            default: u = uc_op(OP_CHKPOS, R_TMP, R_TMP, R_TMP, NB_X);
        endcase
        return u;
    endfunction

    // Signed difference of two Q16.16 coordinates
    function automatic logic [COORD_W:0] coord_diff(logic [COORD_W-1:0] p,
                                                    logic [COORD_W-1:0] q);
        return {p[COORD_W-1], p} - {q[COORD_W-1], q};
    endfunction

    function automatic wide_t widen_diff(logic [COORD_W:0] d);
        return {{(WIDE_W-COORD_W-1){d[COORD_W]}}, d};
    endfunction

endpackage

`default_nettype wire

// ===== sv/pomf_alu.sv =====
// Shared wide arithmetic unit: shift-add multiplier, add/sub, min and sign checks.
// Depends on pomf_pkg.
`default_nettype none

module pomf_alu import pomf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  alu_cmd_t  cmd,
    input  wide_t     a,
    input  wide_t     b,
    output alu_stat_t stat,
    output wide_t     res
);

    logic            run_reg;
    logic            done_reg;
    logic            fail_reg;
    wide_t           acc_reg;
    wide_t           ash_reg;
    wide_t           bsh_reg;
    logic [NB_W-1:0] cnt_reg;
    wide_t           res_reg;

    logic  last;
    wide_t addend;
    wide_t add_x;
    wide_t add_y;
    logic  add_sub;
    wide_t sum;

    // One adder serves both the multiply steps and the add, subtract and min ops
    always_comb
    begin
        last    = (cnt_reg == NB_W'(1));
        addend  = bsh_reg[0] ? ash_reg : '0;
        add_x   = run_reg ? acc_reg : a;
        add_y   = run_reg ? addend : b;
        add_sub = run_reg ? last : (cmd.op != OP_ADD);
        sum     = add_x + (add_y ^ {WIDE_W{add_sub}}) + {{(WIDE_W-1){1'b0}}, add_sub};
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (run_reg)
            begin
                if (last)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (start)
            begin
                if (cmd.op == OP_MUL)
                    run_reg <= 1'b1;
                else
                    done_reg <= 1'b1;
            end
        end
    end

    // Datapath: the top multiplier bit carries negative weight
    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            acc_reg <= sum;
            ash_reg <= ash_reg << 1;
            bsh_reg <= bsh_reg >> 1;
            cnt_reg <= cnt_reg - NB_W'(1);
            if (last)
                res_reg <= sum;
        end
        else if (start)
        begin
            acc_reg  <= '0;
            ash_reg  <= a;
            bsh_reg  <= b;
            cnt_reg  <= cmd.nbits;
            fail_reg <= (cmd.op == OP_CHKNN) ? a[WIDE_W-1] : (a[WIDE_W-1] | (a == '0));
            case (cmd.op)
                OP_ADD, OP_SUB: res_reg <= sum;
                OP_MIN:         res_reg <= sum[WIDE_W-1] ? a : b;
                default:        res_reg <= a;
            endcase
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign stat.fail = fail_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== sv/point_on_mesh_face_test_top.sv =====
// Point-on-mesh face test: vertex/triangle tables, microcoded walk over triangles.
// Table writes are taken while idle; a query walks the triangles, running the microcode on each
// (the shared shift-add multiplier does one multiplier bit per cycle).
// One item at a time; the result waits in an output register while the next item is taken.
// Reset clears control and configuration; the tables hold no reset value until written.
// Depends on pomf_pkg, pomf_alu and point_on_mesh_face_test_top_defines.svh.
`default_nettype none
`include "point_on_mesh_face_test_top_defines.svh"

module point_on_mesh_face_test_top import pomf_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               command,
    input  logic [VA_W-1:0]          vertex_slot,
    input  logic signed [COORD_W-1:0] vertex_x,
    input  logic signed [COORD_W-1:0] vertex_y,
    input  logic signed [COORD_W-1:0] vertex_z,
    input  logic [TA_W-1:0]          triangle_slot,
    input  logic [VA_W-1:0]          corner_a,
    input  logic [VA_W-1:0]          corner_b,
    input  logic [VA_W-1:0]          corner_c,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     on_face,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [THR_W-1:0]         cfg_data
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_NEXT  = 11'b00000000010,
        S_TRI   = 11'b00000000100,
        S_VA    = 11'b00000001000,
        S_VB    = 11'b00000010000,
        S_VC    = 11'b00000100000,
        S_LOAD  = 11'b00001000000,
        S_FETCH = 11'b00010000000,
        S_ISSUE = 11'b00100000000,
        S_WAIT  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    localparam int unsigned VTX_W = 3 * COORD_W;
    localparam int unsigned TRI_W = 3 * VA_W;
    localparam logic [3:0] LD_LAST = 4'd11;

    state_t state_reg, state_next;

    logic [THR_W-1:0] thr_reg;
    logic [FC_W-1:0]  fc_reg;
    logic [FC_W-1:0]  n_reg;
    logic [FC_W-1:0]  tri_idx_reg;
    logic [PC_W-1:0]  pc_reg;
    logic [3:0]       ld_cnt_reg;
    logic             hit_reg;
    logic             out_valid_reg;
    logic             on_face_reg;
    logic [VTX_W-1:0] p_reg;
    logic [VTX_W-1:0] a_reg;
    logic [VTX_W-1:0] b_reg;
    logic [VTX_W-1:0] c_reg;

    logic [VTX_W-1:0] vmem [MAX_VERTICES];
    logic [TRI_W-1:0] tmem [MAX_TRIANGLES];
    wide_t            rf   [2**RF_AW];

    logic [VTX_W-1:0] vrd_data;
    logic [TRI_W-1:0] trd_data;
    logic [VA_W-1:0]  vrd_addr;
    wide_t            rf_a_data;
    wide_t            rf_b_data;

    logic             rf_we;
    logic [RF_AW-1:0] rf_waddr;
    wide_t            rf_wdata;

    logic      in_acc;
    uc_t       uc;
    alu_cmd_t  alu_cmd;
    alu_stat_t alu_stat;
    wide_t     alu_res;
    logic      alu_start;
    logic      is_check;
    logic [THR_W:0] thr1;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign on_face   = on_face_reg;

    assign uc       = uc_rom(pc_reg);
    assign is_check = (uc.op == OP_CHKNN) || (uc.op == OP_CHKPOS);
    assign thr1     = {1'b0, thr_reg} + (THR_W+1)'(32'h10000);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
            fc_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:  thr_reg <= cfg_data;
                CFG_FACE_COUNT: fc_reg  <= cfg_data[FC_W-1:0];
                default:        thr_reg <= thr_reg;
            endcase
        end
    end

    // Vertex table: written by command items, read by the walk
    always_comb
    begin
        case (state_reg)
            S_TRI:   vrd_addr = trd_data[3*VA_W-1:2*VA_W];
            S_VA:    vrd_addr = trd_data[2*VA_W-1:VA_W];
            default: vrd_addr = trd_data[VA_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && (command == CMD_VERTEX))
            vmem[vertex_slot] <= {vertex_x, vertex_y, vertex_z};
        vrd_data <= vmem[vrd_addr];
    end

    // Triangle table
    always_ff @(posedge clk)
    begin
        if (in_acc && (command == CMD_TRIANGLE))
            tmem[triangle_slot] <= {corner_a, corner_b, corner_c};
        trd_data <= tmem[tri_idx_reg[TA_W-1:0]];
    end

    // Operand register file
    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf[rf_waddr] <= rf_wdata;
        rf_a_data <= rf[uc.src_a];
        rf_b_data <= rf[uc.src_b];
    end

    // Select register file write: edge, offset and constant loads, then unit results
    always_comb
    begin
        rf_we    = 1'b0;
        rf_waddr = uc.dst;
        rf_wdata = alu_res;
        if (state_reg == S_LOAD)
        begin
            rf_we = 1'b1;
            case (ld_cnt_reg)
                4'd0: begin rf_waddr = R_E1X;
                    rf_wdata = widen_diff(coord_diff(b_reg[95:64], a_reg[95:64])); end
                4'd1: begin rf_waddr = R_E1Y;
                    rf_wdata = widen_diff(coord_diff(b_reg[63:32], a_reg[63:32])); end
                4'd2: begin rf_waddr = R_E1Z;
                    rf_wdata = widen_diff(coord_diff(b_reg[31:0], a_reg[31:0])); end
                4'd3: begin rf_waddr = R_E2X;
                    rf_wdata = widen_diff(coord_diff(c_reg[95:64], a_reg[95:64])); end
                4'd4: begin rf_waddr = R_E2Y;
                    rf_wdata = widen_diff(coord_diff(c_reg[63:32], a_reg[63:32])); end
                4'd5: begin rf_waddr = R_E2Z;
                    rf_wdata = widen_diff(coord_diff(c_reg[31:0], a_reg[31:0])); end
                4'd6: begin rf_waddr = R_WX;
                    rf_wdata = widen_diff(coord_diff(p_reg[95:64], a_reg[95:64])); end
                4'd7: begin rf_waddr = R_WY;
                    rf_wdata = widen_diff(coord_diff(p_reg[63:32], a_reg[63:32])); end
                4'd8: begin rf_waddr = R_WZ;
                    rf_wdata = widen_diff(coord_diff(p_reg[31:0], a_reg[31:0])); end
                4'd9: begin rf_waddr = R_THR;
                    rf_wdata = {{(WIDE_W-THR_W){1'b0}}, thr_reg}; end
                4'd10: begin rf_waddr = R_THR1;
                    rf_wdata = {{(WIDE_W-THR_W-1){1'b0}}, thr1}; end
                default: begin rf_waddr = R_ONE;
                    rf_wdata = {{(WIDE_W-17){1'b0}}, 1'b1, 16'h0000}; end
            endcase
        end
        else if ((state_reg == S_WAIT) && alu_stat.done && !is_check)
        begin
            rf_we = 1'b1;
        end
    end

    // Shared arithmetic unit
    assign alu_start     = (state_reg == S_ISSUE);
    assign alu_cmd.op    = uc.op;
    assign alu_cmd.nbits = uc.nbits;

    pomf_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (alu_start),
        .cmd   (alu_cmd),
        .a     (rf_a_data),
        .b     (rf_b_data),
        .stat  (alu_stat),
        .res   (alu_res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_acc && (command == CMD_QUERY))
                    state_next = S_NEXT;
            S_NEXT:
                state_next = (tri_idx_reg >= n_reg) ? S_DONE : S_TRI;
            S_TRI:   state_next = S_VA;
            S_VA:    state_next = S_VB;
            S_VB:    state_next = S_VC;
            S_VC:    state_next = S_LOAD;
            S_LOAD:
                if (ld_cnt_reg == LD_LAST)
                    state_next = S_FETCH;
            S_FETCH: state_next = S_ISSUE;
            S_ISSUE: state_next = S_WAIT;
            S_WAIT:
                if (alu_stat.done)
                begin
                    if (is_check && alu_stat.fail)
                        state_next = S_NEXT;
                    else if (is_check && (pc_reg == PC_W'(UC_LEN-1)))
                        state_next = S_DONE;
                    else
                        state_next = S_FETCH;
                end
            S_DONE:
                if (!out_valid_reg)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer registers and output item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            tri_idx_reg   <= '0;
            pc_reg        <= '0;
            ld_cnt_reg    <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            on_face_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_acc && (command == CMD_QUERY))
                    begin
                        n_reg       <= (fc_reg > FC_W'(MAX_TRIANGLES)) ?
                                       FC_W'(MAX_TRIANGLES) : fc_reg;
                        tri_idx_reg <= '0;
                        hit_reg     <= 1'b0;
                    end
                S_VC:   ld_cnt_reg <= '0;
                S_LOAD:
                begin
                    ld_cnt_reg <= ld_cnt_reg + 4'd1;
                    pc_reg     <= '0;
                end
                S_WAIT:
                    if (alu_stat.done)
                    begin
                        if (is_check && alu_stat.fail)
                            tri_idx_reg <= tri_idx_reg + FC_W'(1);
                        else if (is_check && (pc_reg == PC_W'(UC_LEN-1)))
                            hit_reg <= 1'b1;
                        else
                            pc_reg <= pc_reg + PC_W'(1);
                    end
                S_DONE:
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        on_face_reg   <= hit_reg;
                    end
                default: ;
            endcase
        end
    end

    // Hold the query point and the three corners
    always_ff @(posedge clk)
    begin
        if (in_acc && (command == CMD_QUERY))
            p_reg <= {point_x, point_y, point_z};
        if (state_reg == S_VA)
            a_reg <= vrd_data;
        if (state_reg == S_VB)
            b_reg <= vrd_data;
        if (state_reg == S_VC)
            c_reg <= vrd_data;
    end

    `POMF_ASSERT_SAME(a_alu_busy_wait, alu_stat.busy, state_reg == S_WAIT,
        "arithmetic unit busy outside wait state")
    `POMF_ASSERT_SAME(a_walk_bound, state_reg != S_IDLE, tri_idx_reg <= n_reg,
        "triangle index ran past the walk length")
    `POMF_ASSERT_SAME(a_pc_range, state_reg == S_FETCH, pc_reg < PC_W'(UC_LEN),
        "microcode counter out of range")
    `POMF_ASSERT_NEXT(a_done_posts, (state_reg == S_DONE) && !out_valid_reg,
        out_valid_reg && (state_reg == S_IDLE), "finished query did not post its item")

endmodule

`default_nettype wire

// ===== sim/point_on_mesh_face_checker.sv =====
// Checker for the point-on-mesh face test: mirrors the vertex and triangle tables,
// predicts on_face for every accepted query and compares it with the returned items.
// Depends on pomf_pkg for the command and configuration codes.
module point_on_mesh_face_checker import pomf_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [1:0]                command,
    input  logic [VA_W-1:0]           vertex_slot,
    input  logic signed [COORD_W-1:0] vertex_x,
    input  logic signed [COORD_W-1:0] vertex_y,
    input  logic signed [COORD_W-1:0] vertex_z,
    input  logic [TA_W-1:0]           triangle_slot,
    input  logic [VA_W-1:0]           corner_a,
    input  logic [VA_W-1:0]           corner_b,
    input  logic [VA_W-1:0]           corner_c,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic                      on_face,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [THR_W-1:0]          cfg_data,
    output int                        mismatches,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] big_t;

    logic signed [COORD_W-1:0] vert_x [MAX_VERTICES];
    logic signed [COORD_W-1:0] vert_y [MAX_VERTICES];
    logic signed [COORD_W-1:0] vert_z [MAX_VERTICES];
    logic [VA_W-1:0]           tri_a  [MAX_TRIANGLES];
    logic [VA_W-1:0]           tri_b  [MAX_TRIANGLES];
    logic [VA_W-1:0]           tri_c  [MAX_TRIANGLES];
    logic [THR_W-1:0]          threshold;
    logic [FC_W-1:0]           faces_used;
    bit                        face_hits_q[$];

    assign pending = face_hits_q.size();

    function automatic big_t dot3(big_t a0, big_t a1, big_t a2, big_t b0, big_t b1, big_t b2);
        return a0 * b0 + a1 * b1 + a2 * b2;
    endfunction

    // Barycentric test of one stored triangle against point p, exact in wide integers
    function automatic bit face_accepts(int unsigned idx, big_t px, big_t py, big_t pz);
        big_t ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z, e3x, e3y, e3z, wx, wy, wz;
        big_t d00, d01, d02, d11, d12, d22, den, nu, nv, tw, thr, lmin, nx, ny, nz, nw;
        ax = vert_x[tri_a[idx]];
        ay = vert_y[tri_a[idx]];
        az = vert_z[tri_a[idx]];
        e1x = big_t'(vert_x[tri_b[idx]]) - ax;
        e1y = big_t'(vert_y[tri_b[idx]]) - ay;
        e1z = big_t'(vert_z[tri_b[idx]]) - az;
        e2x = big_t'(vert_x[tri_c[idx]]) - ax;
        e2y = big_t'(vert_y[tri_c[idx]]) - ay;
        e2z = big_t'(vert_z[tri_c[idx]]) - az;
        e3x = e2x - e1x;
        e3y = e2y - e1y;
        e3z = e2z - e1z;
        wx = px - ax;
        wy = py - ay;
        wz = pz - az;
        d00 = dot3(e2x, e2y, e2z, e2x, e2y, e2z);
        d01 = dot3(e2x, e2y, e2z, e1x, e1y, e1z);
        d02 = dot3(e2x, e2y, e2z, wx, wy, wz);
        d11 = dot3(e1x, e1y, e1z, e1x, e1y, e1z);
        d12 = dot3(e1x, e1y, e1z, wx, wy, wz);
        d22 = dot3(e3x, e3y, e3z, e3x, e3y, e3z);
        den = d00 * d11 - d01 * d01;
        // skip degenerate triangles
        if (den <= 0)
            return 1'b0;
        nu = d11 * d02 - d01 * d12;
        nv = d00 * d12 - d01 * d02;
        thr = big_t'({1'b0, threshold});
        tw = thr * den;
        if (nu * 65536 + tw < 0)
            return 1'b0;
        if (nv * 65536 + tw < 0)
            return 1'b0;
        if ((thr + 65536) * den - (nu + nv) * 65536 < 0)
            return 1'b0;
        lmin = d11;
        if (d00 < lmin)
            lmin = d00;
        if (d22 < lmin)
            lmin = d22;
        nx = e1y * e2z - e1z * e2y;
        ny = e1z * e2x - e1x * e2z;
        nz = e1x * e2y - e1y * e2x;
        nw = nx * wx + ny * wy + nz * wz;
        return (lmin * den - nw * nw) > 0;
    endfunction

    function automatic bit point_on_mesh(big_t px, big_t py, big_t pz);
        int unsigned n;
        n = (faces_used > MAX_TRIANGLES) ? MAX_TRIANGLES : faces_used;
        for (int unsigned i = 0; i < n; i++)
            if (face_accepts(i, px, py, pz))
                return 1'b1;
        return 1'b0;
    endfunction

    // Track configuration and table writes, predict each query
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold  <= '0;
            faces_used <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_THRESHOLD)
                    threshold <= cfg_data;
                else
                    faces_used <= cfg_data[FC_W-1:0];
            end
            if (in_valid && !in_stall)
            begin
                case (command)
                    CMD_VERTEX:
                    begin
                        vert_x[vertex_slot] = vertex_x;
                        vert_y[vertex_slot] = vertex_y;
                        vert_z[vertex_slot] = vertex_z;
                    end
                    CMD_TRIANGLE:
                    begin
                        tri_a[triangle_slot] = corner_a;
                        tri_b[triangle_slot] = corner_b;
                        tri_c[triangle_slot] = corner_c;
                    end
                    CMD_QUERY:
                        face_hits_q.push_back(point_on_mesh(point_x, point_y, point_z));
                    default: ;
                endcase
            end
        end
    end

    // Compare each returned item with the oldest prediction
    initial
    begin
        mismatches = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (face_hits_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: on_face item %0b with no query pending", $time, on_face);
                    mismatches++;
                end
                else
                begin
                    if (face_hits_q[0] !== on_face)
                    begin
                        if (mismatches < 10)
                            $display("%0t: on_face expected %0b got %0b", $time,
                                     face_hits_q[0], on_face);
                        mismatches++;
                    end
                    void'(face_hits_q.pop_front());
                end
            end
        end
    end
endmodule

// ===== sim/tb.sv =====
// Testbench top for the point-on-mesh face test: clock, reset, stimulus and verdict.
// Depends on pomf_pkg, point_on_mesh_face_test_top and point_on_mesh_face_checker.
module tb;
    import pomf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 200000;
    localparam int LONG_HOLD  = 3000;
    localparam logic [31:0] ONE_Q = 32'h0001_0000;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall, on_face;
    logic [1:0] command;
    logic [VA_W-1:0] vertex_slot, corner_a, corner_b, corner_c;
    logic [TA_W-1:0] triangle_slot;
    logic signed [COORD_W-1:0] vertex_x, vertex_y, vertex_z, point_x, point_y, point_z;
    logic cfg_valid, cfg_ready, cfg_index;
    logic [THR_W-1:0] cfg_data;
    int mismatches, pending;

    // Stimulus-side copy of the tables, used to aim query points at faces
    int  vx [MAX_VERTICES];
    int  vy [MAX_VERTICES];
    int  vz [MAX_VERTICES];
    int  used_verts[$];
    int  ta [MAX_TRIANGLES];
    int  tbv[MAX_TRIANGLES];
    int  tc [MAX_TRIANGLES];
    int  faces_now;
    bit  burst;
    bit  long_hold;
    bit  out_took;
    int  idle_cycles;

    point_on_mesh_face_test_top uut (.*);
    point_on_mesh_face_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        out_took <= out_valid && !out_stall;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stall per item, plus one long hold on request
    initial
    begin
        int wait_left;
        wait_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (out_took)
                wait_left = burst ? 0 : $urandom_range(0, 17);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end
            else if (out_valid && wait_left > 0)
            begin
                out_stall <= 1'b1;
                wait_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic idle_gap();
        int gap;
        gap = burst ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Offer one item and hold it until taken
    task automatic push_item(logic [1:0] cmd, logic [9:0] slot, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [9:0] a, logic [9:0] b, logic [9:0] c);
        idle_gap();
        @(negedge clk);
        command       <= cmd;
        vertex_slot   <= slot;
        triangle_slot <= slot;
        vertex_x      <= x;
        vertex_y      <= y;
        vertex_z      <= z;
        point_x       <= x;
        point_y       <= y;
        point_z       <= z;
        corner_a      <= a;
        corner_b      <= b;
        corner_c      <= c;
        in_valid      <= 1'b1;
        #1;
        while (in_stall)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
    endtask

    task automatic put_vertex(int slot, int x, int y, int z);
        push_item(CMD_VERTEX, slot, x, y, z, $urandom, $urandom, $urandom);
        if (vx[slot] === 32'bx || !(slot inside {used_verts}))
            used_verts.push_back(slot);
        vx[slot] = x;
        vy[slot] = y;
        vz[slot] = z;
    endtask

    task automatic put_face(int slot, int a, int b, int c);
        push_item(CMD_TRIANGLE, slot, $urandom, $urandom, $urandom, a, b, c);
        ta[slot]  = a;
        tbv[slot] = b;
        tc[slot]  = c;
    endtask

    task automatic query(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        push_item(CMD_QUERY, $urandom, x, y, z, $urandom, $urandom, $urandom);
    endtask

    // Write a register once every queued answer is back and the block is quiet
    task automatic set_reg(logic idx, logic [THR_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        #1;
        while (!cfg_ready)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_FACE_COUNT)
            faces_now = value;
    endtask

    // Point near a stored face: A + (ka*e1 + kb*e2)/16, lifted a little off the plane
    task automatic aimed_query();
        int f, a, b, c, ka, kb;
        longint px, py, pz;
        f  = $urandom_range(0, faces_now - 1);
        a  = ta[f];
        b  = tbv[f];
        c  = tc[f];
        ka = $urandom_range(0, 20) - 2;
        kb = $urandom_range(0, 20 - ka) - 2;
        px = vx[a] + (ka * (longint'(vx[b]) - vx[a]) + kb * (longint'(vx[c]) - vx[a])) / 16;
        py = vy[a] + (ka * (longint'(vy[b]) - vy[a]) + kb * (longint'(vy[c]) - vy[a])) / 16;
        pz = vz[a] + (ka * (longint'(vz[b]) - vz[a]) + kb * (longint'(vz[c]) - vz[a])) / 16;
        pz += $signed($urandom_range(0, 2 * 32'h8000)) - 32'sh8000;
        query(px[31:0], py[31:0], pz[31:0]);
    endtask

    function automatic int rand_coord();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
    endfunction

    initial
    begin
        int items, pick;
        in_valid = 1'b0;
        command = CMD_VERTEX;
        vertex_slot = '0;
        triangle_slot = '0;
        corner_a = '0;
        corner_b = '0;
        corner_c = '0;
        vertex_x = '0;
        vertex_y = '0;
        vertex_z = '0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_data = '0;
        burst = 1'b0;
        long_hold = 1'b0;
        idle_cycles = 0;
        faces_now = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: unit triangle, a collinear and a coincident face, extreme corners
        set_reg(CFG_THRESHOLD, '0);
        set_reg(CFG_FACE_COUNT, '0);
        put_vertex(0, 0, 0, 0);
        put_vertex(1, ONE_Q, 0, 0);
        put_vertex(2, 0, ONE_Q, 0);
        put_vertex(4, 2 * ONE_Q, 0, 0);
        put_vertex(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        put_vertex(1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        put_face(0, 0, 1, 4);
        put_face(1, 3, 3, 3);
        put_face(2, 1023, 3, 0);
        put_face(3, 0, 1, 2);
        put_face(1023, 1023, 1023, 1023);
        query(32'h4000, 32'h4000, 0);
        set_reg(CFG_FACE_COUNT, 4);
        query(32'h4000, 32'h4000, 0);
        query(ONE_Q, ONE_Q, 0);
        query(32'h8000, 32'h8000, 0);
        query(32'hFFFF_FF00, 32'h4000, 0);
        query(32'h4000, 32'h4000, 2 * ONE_Q);
        query(32'h4000, 32'h4000, 32'h8000);
        query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        set_reg(CFG_THRESHOLD, 20'hFFFFF);
        query(32'hFFFF_FF00, 32'h4000, 0);
        query(ONE_Q, ONE_Q, 0);
        // Counts at and above the table depth; the walk ends on the good face
        set_reg(CFG_FACE_COUNT, 11'd2047);
        query(32'h2000, 32'h2000, 32'h100);
        set_reg(CFG_FACE_COUNT, 11'd1024);
        query(32'h1000, 32'h3000, 0);
        push_item(CMD_UNUSED, 10'h3FF, '1, '1, '1, '1, '1, '1);
        items = 25;

        // Fill more faces so random counts up to six walk only written entries
        put_face(4, 0, 2, 1);
        put_face(5, 1, 2, 0);
        for (int i = 0; i < 8; i++)
            put_vertex($urandom_range(5, 1022), rand_coord(), rand_coord(), rand_coord());

        // Random phases, each under its own threshold and face count
        for (int ph = 0; items < 580; ph++)
        begin
            case (ph % 4)
                0: set_reg(CFG_THRESHOLD, '0);
                1: set_reg(CFG_THRESHOLD, 20'hFFFFF);
                default: set_reg(CFG_THRESHOLD, $urandom_range(0, 20'h4000));
            endcase
            set_reg(CFG_FACE_COUNT, (ph == 0) ? 6 : $urandom_range(1, 6));
            if (ph == 0)
                long_hold = 1'b1;
            for (int k = 0; k < 70 && items < 580; k++)
            begin
                if (k % 20 == 0)
                    burst = ($urandom_range(0, 2) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    put_vertex($urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
                else if (pick < 38)
                    put_face($urandom_range(0, 1023),
                             used_verts[$urandom_range(0, used_verts.size() - 1)],
                             used_verts[$urandom_range(0, used_verts.size() - 1)],
                             used_verts[$urandom_range(0, used_verts.size() - 1)]);
                else if (pick < 72)
                    aimed_query();
                else if (pick < 95)
                    query($urandom, $urandom, $urandom);
                else
                begin
                    push_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom);
                    items--;
                end
                items++;
            end
            burst = 1'b0;
        end

        // Drain and give the verdict
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== point_on_mesh_face_test_top.f =====
+incdir+sv
sv/pomf_pkg.sv
sv/pomf_alu.sv
sv/point_on_mesh_face_test_top.sv
sim/point_on_mesh_face_checker.sv
sim/tb.sv
